// ----- hdl/lpas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpas_pkg
// Shared types, register indexes, action and phase codes for the long press
// action sequencer.
// ----------------------------------------------------------------------------
package lpas_pkg;

  localparam int NUM_THR   = 6;
  localparam int THR_W     = 16;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 16;
  localparam int ACT_W     = 3;

  localparam int DEF_RESET_PULSE_MS = 200;
  localparam int DEF_SWAP_PULSE_MS  = 300;
  localparam int DEF_EXROM_HOLD_MS  = 300;
  localparam int DEF_TIME_BITS      = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR_RESET_DRIVE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_SWAP_DISK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_WARM_RESTART = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_COLD_RESTART = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_ADDR_TOGGLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_ROM_TOGGLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_MS          = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_SETTINGS    = 3'd7;

  // register reset values
  localparam logic [THR_W-1:0] RST_THR_RESET_DRIVE  = 16'd200;
  localparam logic [THR_W-1:0] RST_THR_SWAP_DISK    = 16'd500;
  localparam logic [THR_W-1:0] RST_THR_WARM_RESTART = 16'd1000;
  localparam logic [THR_W-1:0] RST_THR_COLD_RESTART = 16'd1500;
  localparam logic [THR_W-1:0] RST_THR_ADDR_TOGGLE  = 16'd2000;
  localparam logic [THR_W-1:0] RST_THR_ROM_TOGGLE   = 16'd2500;
  localparam logic [THR_W-1:0] RST_BEEP_MS          = 16'd100;
  localparam logic [1:0]       RST_BOOT_SETTINGS    = 2'd0;

  // action codes: number of thresholds reached
  localparam logic [ACT_W-1:0] ACT_NONE         = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RESET_DRIVE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SWAP_DISK    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WARM_RESTART = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COLD_RESTART = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ADDR_TOGGLE  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_ROM_TOGGLE   = 3'd6;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_DRV   = 6'b000010,
    PH_SWAP  = 6'b000100,
    PH_WARM  = 6'b001000,
    PH_COLD  = 6'b010000,
    PH_EXROM = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [NUM_THR-1:0][THR_W-1:0] thr;
    logic [THR_W-1:0]              beep_ms;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic [1:0] value;
  } boot_t;

  typedef struct packed {
    logic       buzzer_n;
    logic       drive_reset_n;
    logic       disk_swap_n;
    logic       machine_reset_n;
    logic       exrom_n;
    logic       kernal_select;
    logic       card_addr_sel;
    logic       drive_addr_sel;
    logic       busy_res;
    logic       save_strobe;
    logic [1:0] saved_settings;
  } result_t;

endpackage

// ----- hdl/lpas_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpas_cfg_regs
// Threshold and beep time registers, and the boot settings load request.
// ----------------------------------------------------------------------------
module lpas_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [lpas_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [lpas_pkg::CFG_W-1:0]     wr_data,
  output lpas_pkg::cfg_t                 cfg,
  output lpas_pkg::boot_t                boot
);
  import lpas_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr[0]  <= RST_THR_RESET_DRIVE;
      cfg.thr[1]  <= RST_THR_SWAP_DISK;
      cfg.thr[2]  <= RST_THR_WARM_RESTART;
      cfg.thr[3]  <= RST_THR_COLD_RESTART;
      cfg.thr[4]  <= RST_THR_ADDR_TOGGLE;
      cfg.thr[5]  <= RST_THR_ROM_TOGGLE;
      cfg.beep_ms <= RST_BEEP_MS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_THR_RESET_DRIVE:  cfg.thr[0]  <= wr_data[THR_W-1:0];
        REG_THR_SWAP_DISK:    cfg.thr[1]  <= wr_data[THR_W-1:0];
        REG_THR_WARM_RESTART: cfg.thr[2]  <= wr_data[THR_W-1:0];
        REG_THR_COLD_RESTART: cfg.thr[3]  <= wr_data[THR_W-1:0];
        REG_THR_ADDR_TOGGLE:  cfg.thr[4]  <= wr_data[THR_W-1:0];
        REG_THR_ROM_TOGGLE:   cfg.thr[5]  <= wr_data[THR_W-1:0];
        REG_BEEP_MS:          cfg.beep_ms <= wr_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // boot settings go straight to the flags in the core
  always_comb begin
    boot.load  = wr_en && (wr_index == REG_BOOT_SETTINGS);
    boot.value = wr_data[1:0];
  end

endmodule

// ----- hdl/lpas_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpas_core
// Press timing, action selection and pulse sequencer; one tick per step.
// ----------------------------------------------------------------------------
module lpas_core #(
  parameter int TIME_BITS      = lpas_pkg::DEF_TIME_BITS,
  parameter int RESET_PULSE_MS = lpas_pkg::DEF_RESET_PULSE_MS,
  parameter int SWAP_PULSE_MS  = lpas_pkg::DEF_SWAP_PULSE_MS,
  parameter int EXROM_HOLD_MS  = lpas_pkg::DEF_EXROM_HOLD_MS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              button_level,
  input  lpas_pkg::cfg_t    cfg,
  input  lpas_pkg::boot_t   boot,
  output lpas_pkg::result_t res
);
  import lpas_pkg::*;

  localparam int CW = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  function automatic logic [CNT_W-1:0] phase_len(input phase_t ph);
    logic [CNT_W-1:0] len;
    unique case (ph)
      PH_SWAP:  len = CNT_W'(SWAP_PULSE_MS);
      PH_EXROM: len = CNT_W'(EXROM_HOLD_MS);
      default:  len = CNT_W'(RESET_PULSE_MS);
    endcase
    return len;
  endfunction

  logic                 press_active, press_active_next;
  logic [TIME_BITS-1:0] press_time, press_time_next;
  logic [ACT_W-1:0]     chosen_action, chosen_action_next;
  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     phase_count, phase_count_next;
  logic                 addr8_flag, addr8_flag_next;
  logic                 alt_rom_flag, alt_rom_flag_next;

  logic [NUM_THR-1:0] reached;
  logic [ACT_W-1:0]   sel;
  logic               run;
  logic [THR_W-1:0]   thr_sel;
  logic [CW-1:0]      beep_diff;
  logic [CNT_W:0]     count_inc;
  logic               pressed;

  always_comb begin
    pressed            = ~button_level;
    press_active_next  = press_active;
    press_time_next    = press_time;
    chosen_action_next = chosen_action;
    phase_next         = phase;
    phase_count_next   = phase_count;
    addr8_flag_next    = addr8_flag;
    alt_rom_flag_next  = alt_rom_flag;
    reached            = '0;
    sel                = ACT_NONE;
    run                = 1'b1;
    thr_sel            = '0;
    beep_diff          = '0;
    count_inc          = '0;

    res.buzzer_n        = 1'b1;
    res.drive_reset_n   = 1'b1;
    res.disk_swap_n     = 1'b1;
    res.machine_reset_n = 1'b1;
    res.exrom_n         = 1'b1;
    res.busy_res        = 1'b0;
    res.save_strobe     = 1'b0;

    if (phase == PH_IDLE) begin
      if (pressed) begin
        if (!press_active) begin
          press_active_next = 1'b1;
          press_time_next   = '0;
        end else if (press_time != TIME_MAX) begin
          press_time_next = press_time + 1'b1;
        end
        for (int i = 0; i < NUM_THR; i++) begin
          reached[i] = CW'(press_time_next) >= CW'(cfg.thr[i]);
        end
        // leading run of reached thresholds
        for (int i = 0; i < NUM_THR; i++) begin
          if (run && reached[i]) begin
            sel = ACT_W'(i + 1);
          end else begin
            run = 1'b0;
          end
        end
        chosen_action_next = sel;
        if (sel >= ACT_SWAP_DISK) begin
          thr_sel   = cfg.thr[ACT_W'(sel - 1'b1)];
          beep_diff = CW'(press_time_next) - CW'(thr_sel);
          if (beep_diff < CW'(cfg.beep_ms)) begin
            res.buzzer_n = 1'b0;
          end
        end
      end else if (press_active) begin
        press_active_next = 1'b0;
        unique case (chosen_action)
          ACT_RESET_DRIVE:  phase_next = PH_DRV;
          ACT_SWAP_DISK:    phase_next = PH_SWAP;
          ACT_WARM_RESTART: phase_next = PH_WARM;
          ACT_COLD_RESTART: phase_next = PH_COLD;
          ACT_ADDR_TOGGLE: begin
            addr8_flag_next = ~addr8_flag;
            res.save_strobe = 1'b1;
            phase_next      = PH_DRV;
          end
          ACT_ROM_TOGGLE: begin
            alt_rom_flag_next = ~alt_rom_flag;
            res.save_strobe   = 1'b1;
            phase_next        = PH_COLD;
          end
          default: ;
        endcase
        phase_count_next   = '0;
        chosen_action_next = ACT_NONE;
      end
    end

    // the release tick is already the first pulse tick
    if (phase_next != PH_IDLE) begin
      res.busy_res = 1'b1;
      unique case (phase_next)
        PH_DRV:  res.drive_reset_n = 1'b0;
        PH_SWAP: res.disk_swap_n   = 1'b0;
        PH_WARM: res.machine_reset_n = 1'b0;
        PH_COLD: begin
          res.machine_reset_n = 1'b0;
          res.exrom_n         = 1'b0;
        end
        default: res.exrom_n = 1'b0;
      endcase
      count_inc = {1'b0, phase_count_next} + 1'b1;
      if (count_inc >= {1'b0, phase_len(phase_next)}) begin
        phase_next       = (phase_next == PH_COLD) ? PH_EXROM : PH_IDLE;
        phase_count_next = '0;
      end else begin
        phase_count_next = count_inc[CNT_W-1:0];
      end
    end

    res.kernal_select  = ~alt_rom_flag_next;
    res.card_addr_sel  = ~addr8_flag_next;
    res.drive_addr_sel = ~addr8_flag_next;
    res.saved_settings = {alt_rom_flag_next, addr8_flag_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_active  <= 1'b0;
      press_time    <= '0;
      chosen_action <= ACT_NONE;
      phase         <= PH_IDLE;
      phase_count   <= '0;
      addr8_flag    <= RST_BOOT_SETTINGS[0];
      alt_rom_flag  <= RST_BOOT_SETTINGS[1];
    end else if (boot.load) begin
      addr8_flag   <= boot.value[0];
      alt_rom_flag <= boot.value[1];
    end else if (step) begin
      press_active  <= press_active_next;
      press_time    <= press_time_next;
      chosen_action <= chosen_action_next;
      phase         <= phase_next;
      phase_count   <= phase_count_next;
      addr8_flag    <= addr8_flag_next;
      alt_rom_flag  <= alt_rom_flag_next;
    end
  end

`ifndef SYNTHESIS
  a_count_in_phase: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (phase_count < phase_len(phase)))
    else $error("phase count ran past phase length");

  a_no_press_in_seq: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> !press_active)
    else $error("press tracking active during a sequence");

  a_save_starts_seq: assert property (@(posedge clk) disable iff (rst)
    (step && res.save_strobe) |=> (phase == PH_DRV || phase == PH_COLD))
    else $error("save request without toggle sequence");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (phase_count == '0))
    else $error("phase count not cleared in idle");
`endif

endmodule

// ----- hdl/lpas_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpas_out_reg
// Result register on the master side; loads while the previous result leaves.
// ----------------------------------------------------------------------------
module lpas_out_reg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  lpas_pkg::result_t                res,
  output logic                             can_load,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lpas_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import lpas_pkg::*;

  logic [OUT_DATA_W-1:0] packed_res;

  assign can_load = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    packed_res        = '0;
    packed_res[0]     = res.buzzer_n;
    packed_res[1]     = res.drive_reset_n;
    packed_res[2]     = res.disk_swap_n;
    packed_res[3]     = res.machine_reset_n;
    packed_res[4]     = res.exrom_n;
    packed_res[5]     = res.kernal_select;
    packed_res[6]     = res.card_addr_sel;
    packed_res[7]     = res.drive_addr_sel;
    packed_res[8]     = res.busy_res;
    packed_res[9]     = res.save_strobe;
    packed_res[11:10] = res.saved_settings;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= packed_res;
    end
  end

endmodule

// ----- hdl/long_press_action_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// long_press_action_sequencer
// Long press button decoder that runs timed reset, swap and restart pulses.
// ----------------------------------------------------------------------------
// Each request on the slave side is one millisecond tick carrying the raw
// active-low button level. Every tick yields exactly one result request with
// the buzzer, the pulse lines, the select pins, busy and save strobe. One
// tick is taken per clock while the result register can load; a taken tick
// waits in the input register, then the single-pass next-state logic loads
// its result into the result register, from which it leaves when the master
// side takes it. The result register refills in the same cycle its previous
// content leaves. Configuration writes are always ready and take effect on
// the next tick; a boot_settings write loads both flags at once.
module long_press_action_sequencer #(
  parameter int TIME_BITS      = lpas_pkg::DEF_TIME_BITS,
  parameter int RESET_PULSE_MS = lpas_pkg::DEF_RESET_PULSE_MS,
  parameter int SWAP_PULSE_MS  = lpas_pkg::DEF_SWAP_PULSE_MS,
  parameter int EXROM_HOLD_MS  = lpas_pkg::DEF_EXROM_HOLD_MS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] button_level
  input  logic [lpas_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] buzzer_n, [1] drive_reset_n, [2] disk_swap_n, [3] machine_reset_n,
  // [4] exrom_n, [5] kernal_select, [6] card_addr_sel, [7] drive_addr_sel,
  // [8] busy_res, [9] save_strobe, [11:10] saved_settings
  output logic [lpas_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpas_pkg::CFG_W-1:0]      cfg_data
);
  import lpas_pkg::*;

  logic    in_valid;
  logic    in_level;
  logic    can_load;
  logic    advance;
  cfg_t    cfg;
  boot_t   boot;
  result_t res;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && can_load;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_level <= s_axis_tdata[0];
    end
  end

  lpas_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .boot     (boot)
  );

  lpas_core #(
    .TIME_BITS      (TIME_BITS),
    .RESET_PULSE_MS (RESET_PULSE_MS),
    .SWAP_PULSE_MS  (SWAP_PULSE_MS),
    .EXROM_HOLD_MS  (EXROM_HOLD_MS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .button_level (in_level),
    .cfg          (cfg),
    .boot         (boot),
    .res          (res)
  );

  lpas_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .res           (res),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- sim/lpas_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpas_result_checker
// Watches the tick, result and register channels of the long press action
// sequencer, predicts the result of every accepted tick and compares it,
// field by field, with the result requests in order of arrival.
// ----------------------------------------------------------------------------
module lpas_result_checker import lpas_pkg::*; #(
  parameter int TIME_BITS      = DEF_TIME_BITS,
  parameter int RESET_PULSE_MS = DEF_RESET_PULSE_MS,
  parameter int SWAP_PULSE_MS  = DEF_SWAP_PULSE_MS,
  parameter int EXROM_HOLD_MS  = DEF_EXROM_HOLD_MS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    fail_count,
  output int                    pending
);

  // register copies
  logic [THR_W-1:0] thr_set [NUM_THR];
  logic [THR_W-1:0] beep_len;

  // sequencer state
  logic                 held;
  logic [TIME_BITS-1:0] held_ms;
  logic [ACT_W-1:0]     armed_act;
  phase_t               seq_phase;
  int unsigned          seq_ms;
  logic                 addr8;
  logic                 alt_rom;

  result_t due_results[$];
  int      mismatches = 0;
  int      result_no  = 0;

  assign fail_count = mismatches;

  function automatic int unsigned pulse_ticks(input phase_t p);
    case (p)
      PH_SWAP:  return SWAP_PULSE_MS;
      PH_EXROM: return EXROM_HOLD_MS;
      default:  return RESET_PULSE_MS;
    endcase
  endfunction

  function automatic result_t unpack_result(input logic [OUT_DATA_W-1:0] d);
    result_t r;
    r.buzzer_n        = d[0];
    r.drive_reset_n   = d[1];
    r.disk_swap_n     = d[2];
    r.machine_reset_n = d[3];
    r.exrom_n         = d[4];
    r.kernal_select   = d[5];
    r.card_addr_sel   = d[6];
    r.drive_addr_sel  = d[7];
    r.busy_res        = d[8];
    r.save_strobe     = d[9];
    r.saved_settings  = d[11:10];
    return r;
  endfunction

  task automatic restart_model();
    thr_set[0] = RST_THR_RESET_DRIVE;
    thr_set[1] = RST_THR_SWAP_DISK;
    thr_set[2] = RST_THR_WARM_RESTART;
    thr_set[3] = RST_THR_COLD_RESTART;
    thr_set[4] = RST_THR_ADDR_TOGGLE;
    thr_set[5] = RST_THR_ROM_TOGGLE;
    beep_len   = RST_BEEP_MS;
    held       = 1'b0;
    held_ms    = '0;
    armed_act  = ACT_NONE;
    seq_phase  = PH_IDLE;
    seq_ms     = 0;
    addr8      = RST_BOOT_SETTINGS[0];
    alt_rom    = RST_BOOT_SETTINGS[1];
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_THR_RESET_DRIVE:  thr_set[0] = val;
      REG_THR_SWAP_DISK:    thr_set[1] = val;
      REG_THR_WARM_RESTART: thr_set[2] = val;
      REG_THR_COLD_RESTART: thr_set[3] = val;
      REG_THR_ADDR_TOGGLE:  thr_set[4] = val;
      REG_THR_ROM_TOGGLE:   thr_set[5] = val;
      REG_BEEP_MS:          beep_len   = val;
      REG_BOOT_SETTINGS: begin
        addr8   = val[0];
        alt_rom = val[1];
      end
      default: ;
    endcase
  endtask

  // one millisecond tick through the sequencer
  task automatic step_button_tick(input logic level, output result_t res);
    int     n;
    bit     stop;
    longint gap;
    res = '{buzzer_n: 1'b1, drive_reset_n: 1'b1, disk_swap_n: 1'b1,
            machine_reset_n: 1'b1, exrom_n: 1'b1, kernal_select: 1'b1,
            card_addr_sel: 1'b1, drive_addr_sel: 1'b1, busy_res: 1'b0,
            save_strobe: 1'b0, saved_settings: 2'b00};
    n    = 0;
    stop = 0;
    if (seq_phase == PH_IDLE) begin
      if (!level) begin
        if (!held) begin
          held    = 1'b1;
          held_ms = '0;
        end else if (held_ms != {TIME_BITS{1'b1}}) begin
          held_ms = held_ms + 1'b1;
        end
        // count leading thresholds reached, stop at the first miss
        for (int k = 0; k < NUM_THR; k++) begin
          if (!stop && held_ms >= thr_set[k]) n++;
          else stop = 1;
        end
        armed_act = n[ACT_W-1:0];
        if (n >= 2) begin
          gap = longint'(held_ms) - longint'(thr_set[n-1]);
          if (gap < longint'(beep_len)) res.buzzer_n = 1'b0;
        end
      end else if (held) begin
        held = 1'b0;
        case (armed_act)
          ACT_RESET_DRIVE:  seq_phase = PH_DRV;
          ACT_SWAP_DISK:    seq_phase = PH_SWAP;
          ACT_WARM_RESTART: seq_phase = PH_WARM;
          ACT_COLD_RESTART: seq_phase = PH_COLD;
          ACT_ADDR_TOGGLE: begin
            addr8           = !addr8;
            res.save_strobe = 1'b1;
            seq_phase       = PH_DRV;
          end
          ACT_ROM_TOGGLE: begin
            alt_rom         = !alt_rom;
            res.save_strobe = 1'b1;
            seq_phase       = PH_COLD;
          end
          default: ;
        endcase
        seq_ms    = 0;
        armed_act = ACT_NONE;
      end
    end
    if (seq_phase != PH_IDLE) begin
      res.busy_res = 1'b1;
      case (seq_phase)
        PH_DRV:  res.drive_reset_n = 1'b0;
        PH_SWAP: res.disk_swap_n = 1'b0;
        PH_WARM: res.machine_reset_n = 1'b0;
        PH_COLD: begin
          res.machine_reset_n = 1'b0;
          res.exrom_n         = 1'b0;
        end
        default: res.exrom_n = 1'b0;
      endcase
      seq_ms++;
      if (seq_ms >= pulse_ticks(seq_phase)) begin
        seq_phase = (seq_phase == PH_COLD) ? PH_EXROM : PH_IDLE;
        seq_ms    = 0;
      end
    end
    res.kernal_select  = !alt_rom;
    res.card_addr_sel  = !addr8;
    res.drive_addr_sel = !addr8;
    res.saved_settings = {alt_rom, addr8};
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("result %0d %s: expected %0h, got %0h", result_no, name, want, got);
      mismatches++;
    end
  endtask

  initial restart_model();

  always @(posedge clk) begin
    result_t want;
    result_t got;
    result_t next_res;
    if (rst) begin
      restart_model();
      due_results.delete();
      pending <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with nothing expected: %0h", result_no, m_axis_tdata);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          got  = unpack_result(m_axis_tdata);
          check_field("buzzer_n", 4'(want.buzzer_n), 4'(got.buzzer_n));
          check_field("drive_reset_n", 4'(want.drive_reset_n), 4'(got.drive_reset_n));
          check_field("disk_swap_n", 4'(want.disk_swap_n), 4'(got.disk_swap_n));
          check_field("machine_reset_n", 4'(want.machine_reset_n),
                      4'(got.machine_reset_n));
          check_field("exrom_n", 4'(want.exrom_n), 4'(got.exrom_n));
          check_field("kernal_select", 4'(want.kernal_select), 4'(got.kernal_select));
          check_field("card_addr_sel", 4'(want.card_addr_sel), 4'(got.card_addr_sel));
          check_field("drive_addr_sel", 4'(want.drive_addr_sel), 4'(got.drive_addr_sel));
          check_field("busy_res", 4'(want.busy_res), 4'(got.busy_res));
          check_field("save_strobe", 4'(want.save_strobe), 4'(got.save_strobe));
          check_field("saved_settings", 4'(want.saved_settings), 4'(got.saved_settings));
          check_field("pad", 4'd0, m_axis_tdata[15:12]);
        end
        result_no++;
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) begin
        step_button_tick(s_axis_tdata[0], next_res);
        due_results.push_back(next_res);
      end
      pending <= due_results.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives button ticks and register writes into the long press action
// sequencer: a directed pass over every action and corner, then random
// presses under several settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import lpas_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEQ_DRAIN   = 520;   // longer than the longest sequence

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '1;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_THR_RESET_DRIVE;
  logic [CFG_W-1:0]      cfg_data = '0;

  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   ticks_sent = 0;
  logic calm = 1'b0;
  logic rx_hold = 1'b0;
  logic rand_on = 1'b0;

  long_press_action_sequencer #(
    .TIME_BITS      (DEF_TIME_BITS),
    .RESET_PULSE_MS (DEF_RESET_PULSE_MS),
    .SWAP_PULSE_MS  (DEF_SWAP_PULSE_MS),
    .EXROM_HOLD_MS  (DEF_EXROM_HOLD_MS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lpas_result_checker #(
    .TIME_BITS      (DEF_TIME_BITS),
    .RESET_PULSE_MS (DEF_RESET_PULSE_MS),
    .SWAP_PULSE_MS  (DEF_SWAP_PULSE_MS),
    .EXROM_HOLD_MS  (DEF_EXROM_HOLD_MS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side: random stalls, none while calm, nothing during the hold-off
  initial begin
    forever begin
      @(posedge clk);
      m_axis_tready <= !rx_hold && (calm || $urandom_range(99) >= 11);
    end
  end

  // long receiver hold-off once random traffic runs, so the input backs up
  initial begin
    wait (rand_on);
    repeat (200) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_tick(input logic level);
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, level};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // n ticks at one level; counted ones make up the stimulus budget
  task automatic send_run(input logic level, input int n, input bit counted);
    for (int k = 0; k < n; k++) begin
      send_tick(level);
      if (counted) ticks_sent++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] t0, input logic [15:0] t1,
                                input logic [15:0] t2, input logic [15:0] t3,
                                input logic [15:0] t4, input logic [15:0] t5,
                                input logic [15:0] beep, input logic [1:0] boot);
    drain();
    put_reg(REG_THR_RESET_DRIVE, t0);
    put_reg(REG_THR_SWAP_DISK, t1);
    put_reg(REG_THR_WARM_RESTART, t2);
    put_reg(REG_THR_COLD_RESTART, t3);
    put_reg(REG_THR_ADDR_TOGGLE, t4);
    put_reg(REG_THR_ROM_TOGGLE, t5);
    put_reg(REG_BEEP_MS, beep);
    put_reg(REG_BOOT_SETTINGS, {{(CFG_W-2){1'b0}}, boot});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          v [NUM_THR];
    int          base;
    int          reach;
    int          start;
    int          n;
    logic [15:0] bp;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: short press with no action, full press to kernal toggle,
    // then a press held across the end of the sequence
    send_run(1'b1, 3, 1'b1);
    send_run(1'b0, 50, 1'b1);
    send_run(1'b1, 2, 1'b1);
    send_run(1'b0, 2600, 1'b1);
    send_run(1'b1, 1, 1'b1);
    send_run(1'b0, 540, 1'b0);
    send_run(1'b1, 3, 1'b1);

    // zero first threshold: one press length per action
    apply_settings(16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd2, 2'b11);
    for (int len = 1; len <= 7; len++) begin
      send_run(1'b0, len, 1'b1);
      send_run(1'b1, 1, 1'b1);
      send_run(1'b1, SEQ_DRAIN, 1'b0);
    end

    // thresholds out of order: selection stops at the first miss
    apply_settings(16'd3, 16'd1, 16'd10, 16'd0, 16'd4, 16'd4, 16'd5, 2'b00);
    send_run(1'b0, 12, 1'b1);
    send_run(1'b1, 1, 1'b1);
    send_run(1'b1, SEQ_DRAIN, 1'b0);
    send_run(1'b0, 6, 1'b1);
    send_run(1'b1, 1, 1'b1);
    send_run(1'b1, SEQ_DRAIN, 1'b0);

    // unreachable thresholds, no beep: release selects nothing
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'd0, 2'b01);
    send_run(1'b0, 20, 1'b1);
    send_run(1'b1, 2, 1'b1);

    // press time saturation: last action only reached at the top count
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 2'b10);
    calm <= 1'b1;
    send_run(1'b0, 65600, 1'b0);
    calm <= 1'b0;
    send_run(1'b1, 1, 1'b1);
    send_run(1'b1, SEQ_DRAIN, 1'b0);

    rand_on <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      base = $urandom_range(0, 6);
      for (int k = 0; k < NUM_THR; k++) begin
        if ($urandom_range(3) == 0) begin
          v[k] = $urandom_range(0, 40);
        end else begin
          base = base + $urandom_range(1, 10);
          v[k] = base;
        end
      end
      if ($urandom_range(4) == 0) v[$urandom_range(NUM_THR-1)] = 65535;
      if ($urandom_range(4) == 0) v[0] = 0;
      case ($urandom_range(5))
        0:       bp = 16'd0;
        1:       bp = 16'hFFFF;
        default: bp = 16'($urandom_range(1, 12));
      endcase
      apply_settings(16'(v[0]), 16'(v[1]), 16'(v[2]), 16'(v[3]), 16'(v[4]), 16'(v[5]),
                     bp, 2'($urandom_range(3)));
      reach = 0;
      for (int k = 0; k < NUM_THR; k++)
        if (v[k] != 65535 && v[k] > reach) reach = v[k];
      start = ticks_sent;
      while (ticks_sent - start < 185) begin
        if ($urandom_range(99) < 80) begin
          send_run(1'b1, $urandom_range(0, 3), 1'b1);
          send_run(1'b0, $urandom_range(1, reach + 6), 1'b1);
          send_run(1'b1, 1, 1'b1);
          n = $urandom_range(99);
          // mostly let the sequence run out, sometimes press into it
          if (n < 65) send_run(1'b1, SEQ_DRAIN, 1'b0);
          else if (n < 80) send_run(1'b0, SEQ_DRAIN, 1'b0);
          else send_run(1'b1, $urandom_range(0, SEQ_DRAIN), 1'b0);
        end else begin
          n = $urandom_range(1, 30);
          for (int k = 0; k < n; k++) send_run(1'($urandom_range(1)), 1, 1'b1);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lpas_pkg.sv
hdl/lpas_cfg_regs.sv
hdl/lpas_core.sv
hdl/lpas_out_reg.sv
hdl/long_press_action_sequencer.sv
sim/lpas_result_checker.sv
sim/testbench.sv
